@@ rtl/core/bst_pkg.sv @@
// Package for the bitmap slot table: item payload types, operation codes and status codes.
// Used by bitmap_slot_table_top in rtl/core; bst_ram does not use it. Depends on nothing else.
package bst_pkg;

    localparam int IDX_W   = 6;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int LENO_W  = 7;

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NONE  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]  slot;
        logic [VAL_W-1:0]  data;
        logic [STAT_W-1:0] status;
        logic [LENO_W-1:0] length_now;
    } t_out;

endpackage

@@ rtl/core/bst_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/bitmap_slot_table_top.sv @@
// Each item runs through the idle, execute and respond states: execute applies the item with
// the RAM access, and respond loads the registered RAM read into the output register. A new item
// is taken only in idle, after the result is loaded; an untaken result holds the input off.
// Reset is synchronous and clears the occupancy bitmap, the length and the handshakes. The slot
// RAM is not cleared; a free slot reads as zero through its occupancy bit. Depends on bst_pkg
// and bst_ram.
module bitmap_slot_table_top #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bst_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bst_pkg::t_out o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > bst_pkg::IDX_W) ? LW : bst_pkg::IDX_W) + 1;
    localparam int SW = (VALUE_WIDTH < bst_pkg::VAL_W) ? VALUE_WIDTH : bst_pkg::VAL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state                         r_state;
    logic [CAPACITY-1:0]            r_occ;
    logic [LW-1:0]                  r_hw;
    logic [bst_pkg::KIND_W-1:0]     r_kind;
    logic [bst_pkg::IDX_W-1:0]      r_idx;
    logic [SW-1:0]                  r_val;
    logic [AW-1:0]                  r_slot;
    logic [bst_pkg::STAT_W-1:0]     r_status;
    logic                           r_use_data;
    logic                           r_out_valid;
    bst_pkg::t_out                  r_out;

    logic [CAPACITY-1:0]            n_occ;
    logic [LW-1:0]                  n_hw;
    logic [AW-1:0]                  n_slot;
    logic [bst_pkg::STAT_W-1:0]     n_status;
    logic                           n_use_data;

    logic [CAPACITY-1:0]            free_map;
    logic [CAPACITY-1:0]            add_oh;
    logic [AW-1:0]                  add_slot;
    logic [LW-1:0]                  add_len;
    logic                           table_full;
    logic [CAPACITY-1:0]            below_hw;
    logic [CAPACITY-1:0]            next_cand;
    logic [CAPACITY-1:0]            next_oh;
    logic [AW-1:0]                  next_slot;
    logic [CW-1:0]                  idx_ext;
    logic [CW-1:0]                  hw_ext;
    logic [AW-1:0]                  idx_addr;

    logic                           ram_we;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [SW-1:0]                  ram_rdata;

    logic                           in_accept;
    logic                           out_load;

    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_load = (r_state == S_RESP) && (!r_out_valid || i_out_ready);

    assign idx_ext  = CW'(r_idx);
    assign hw_ext   = CW'(r_hw);
    assign idx_addr = AW'(r_idx);

    assign free_map   = ~r_occ;
    assign add_oh     = free_map & (~free_map + CAPACITY'(1));
    assign table_full = &r_occ;
    assign add_len    = LW'(add_slot) + LW'(1);
    assign next_oh    = next_cand & (~next_cand + CAPACITY'(1));

    always_comb begin
        add_slot  = '0;
        next_slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            below_hw[i]  = (CW'(i) < hw_ext);
            next_cand[i] = r_occ[i] && (CW'(i) > idx_ext) && (CW'(i) < hw_ext);
            if (add_oh[i]) begin
                add_slot = add_slot | AW'(i);
            end
            if (next_oh[i]) begin
                next_slot = next_slot | AW'(i);
            end
        end
    end

    always_comb begin
        n_occ      = r_occ;
        n_hw       = r_hw;
        n_slot     = '0;
        n_status   = bst_pkg::STATUS_OK;
        n_use_data = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = idx_addr;
        unique case (r_kind)
            bst_pkg::KIND_ADD: begin
                if (table_full) begin
                    n_status = bst_pkg::STATUS_FULL;
                end else begin
                    n_occ[add_slot] = 1'b1;
                    n_slot          = add_slot;
                    ram_we          = (r_state == S_EXEC);
                    if (add_len > r_hw) begin
                        n_hw = add_len;
                    end
                end
            end
            bst_pkg::KIND_REMOVE: begin
                if (idx_ext >= CW'(CAPACITY)) begin
                    n_status = bst_pkg::STATUS_NONE;
                end else begin
                    n_occ[idx_addr] = 1'b0;
                    if (idx_ext + CW'(1) == hw_ext) begin
                        n_hw = r_hw - LW'(1);
                    end
                end
            end
            bst_pkg::KIND_GET: begin
                if (idx_ext < hw_ext) begin
                    n_use_data = r_occ[idx_addr];
                    ram_re     = (r_state == S_EXEC);
                end else begin
                    n_status = bst_pkg::STATUS_NONE;
                end
            end
            bst_pkg::KIND_NEXT: begin
                ram_raddr = next_slot;
                if (|next_cand) begin
                    n_slot     = next_slot;
                    n_use_data = 1'b1;
                    ram_re     = (r_state == S_EXEC);
                end else begin
                    n_status = bst_pkg::STATUS_NONE;
                end
            end
            bst_pkg::KIND_CLEAR: begin
                n_occ = '0;
                n_hw  = '0;
            end
            default: begin
                n_status = bst_pkg::STATUS_NONE;
            end
        endcase
    end

    bst_ram #(
        .WIDTH(SW),
        .DEPTH(CAPACITY)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(add_slot),
        .i_wdata(r_val),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_kind  <= i_in.kind;
                        r_idx   <= i_in.index;
                        r_val   <= SW'(i_in.value);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_occ      <= n_occ;
                    r_hw       <= n_hw;
                    r_slot     <= n_slot;
                    r_status   <= n_status;
                    r_use_data <= n_use_data;
                    r_state    <= S_RESP;
                end
                S_RESP: begin
                    if (out_load) begin
                        r_out.slot       <= bst_pkg::IDX_W'(r_slot);
                        r_out.data       <= r_use_data ? bst_pkg::VAL_W'(ram_rdata) : '0;
                        r_out.status     <= r_status;
                        r_out.length_now <= bst_pkg::LENO_W'(r_hw);
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ & ~below_hw) == '0)
        else $error("occupied slot at or above the length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= LW'(CAPACITY))
        else $error("length exceeds capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == bst_pkg::STATUS_FULL)
            |-> o_out.length_now == bst_pkg::LENO_W'(CAPACITY))
        else $error("full status reported with a short length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_EXEC) && !table_full)
        else $error("slot write outside an add");

endmodule
